### hdl/cbs_pkg.sv
// Package for the channel breakout signal block.
// Shared constants, register indexes, order codes and the chain control struct.
// Depends on nothing.
`default_nettype none

package cbs_pkg;

	localparam int MAX_WINDOW_DEF = 256;
	localparam int PRICE_BITS_DEF = 32;

	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int WIN_LEN_BITS  = 9;

	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic REG_STRATEGY_MODE = 1'b1;

	localparam logic [WIN_LEN_BITS-1:0] WINDOW_LENGTH_RST = 9'd20;

	localparam logic MODE_PLAIN       = 1'b0;
	localparam logic MODE_LAST_LOSER  = 1'b1;

	localparam logic signed [1:0] ORDER_NONE = 2'sb00;
	localparam logic signed [1:0] ORDER_BUY  = 2'sb01;
	localparam logic signed [1:0] ORDER_SELL = 2'sb11;

	typedef struct packed {
		logic start;
		logic shift;
	} chain_ctl_t;

endpackage

`default_nettype wire

### hdl/cbs_cell.sv
// One cell of the price chain: holds one stored price and one stage of the
// min/max scan wave. Depends on cbs_pkg.
`default_nettype none

module cbs_cell #(
	parameter int IDX        = 0,
	parameter int PRICE_BITS = cbs_pkg::PRICE_BITS_DEF,
	parameter int LEN_W      = 9
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cbs_pkg::chain_ctl_t    chain_ctl,
	input  wire logic [LEN_W-1:0]       win_len,
	input  wire logic [PRICE_BITS-1:0]  price_in,
	output logic      [PRICE_BITS-1:0]  price_out,
	input  wire logic                   tok_in,
	input  wire logic [PRICE_BITS-1:0]  lo_in,
	input  wire logic [PRICE_BITS-1:0]  hi_in,
	output logic                        tok_out,
	output logic      [PRICE_BITS-1:0]  lo_out,
	output logic      [PRICE_BITS-1:0]  hi_out
);

	logic [PRICE_BITS-1:0] price_q;
	logic                  tok_q;
	logic [PRICE_BITS-1:0] lo_q;
	logic [PRICE_BITS-1:0] hi_q;
	logic                  in_use;

	assign in_use = LEN_W'(IDX) < win_len;

	always_ff @(posedge clk) begin
		if (chain_ctl.shift) begin
			price_q <= price_in;
		end
		lo_q <= (in_use && (price_q < lo_in)) ? price_q : lo_in;
		hi_q <= (in_use && (price_q > hi_in)) ? price_q : hi_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	assign price_out = price_q;
	assign tok_out   = tok_q;
	assign lo_out    = lo_q;
	assign hi_out    = hi_q;

endmodule

`default_nettype wire

### hdl/cbs_ctrl.sv
// Sequencer of the channel breakout block: input transfer, scan launch,
// breakout decision, signal state and the output register. Depends on cbs_pkg.
`default_nettype none

module cbs_ctrl #(
	parameter int MAX_WINDOW = cbs_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_BITS = cbs_pkg::PRICE_BITS_DEF,
	parameter int LEN_W      = $clog2(MAX_WINDOW + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              new_candle,
	input  wire logic [31:0]                       close_price,
	input  wire logic                              position_held,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   reset_position,
	output logic signed [1:0]                      trade_order,
	output logic [31:0]                            channel_low,
	output logic [31:0]                            channel_high,
	output logic                                   channel_valid,
	input  wire logic [cbs_pkg::WIN_LEN_BITS-1:0]  window_length,
	input  wire logic                              strategy_mode,
	output logic [LEN_W-1:0]                       win_len,
	output cbs_pkg::chain_ctl_t                    chain_ctl,
	output logic [PRICE_BITS-1:0]                  item_price,
	input  wire logic                              scan_tok,
	input  wire logic [PRICE_BITS-1:0]             scan_lo,
	input  wire logic [PRICE_BITS-1:0]             scan_hi
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	logic [LEN_W-1:0]      fill_q;
	logic                  await_low_q;
	logic                  await_high_q;
	logic [PRICE_BITS-1:0] last_brk_q;
	logic                  out_valid_q;

	logic [PRICE_BITS-1:0] price_q;
	logic                  held_q;
	logic                  candle_q;
	logic                  cmp_q;
	logic [PRICE_BITS-1:0] lo_q;
	logic [PRICE_BITS-1:0] hi_q;

	logic                  rst_out_q;
	logic signed [1:0]     order_out_q;
	logic [31:0]           low_out_q;
	logic [31:0]           high_out_q;
	logic                  cvalid_out_q;

	logic [31:0]           wl_ext;
	logic                  accept;
	logic                  full;
	logic                  start;
	logic                  slot_free;
	logic                  finish;
	logic                  brk_low;
	logic                  brk_high;
	logic                  rst_d;
	logic signed [1:0]     order_d;

	assign wl_ext = 32'(window_length);

	always_comb begin
		if (wl_ext == 32'd0) begin
			win_len = LEN_W'(1);
		end else if (wl_ext > 32'(MAX_WINDOW)) begin
			win_len = LEN_W'(MAX_WINDOW);
		end else begin
			win_len = LEN_W'(window_length);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (fill_q >= win_len);
	assign start     = accept && new_candle && full;
	assign slot_free = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_DONE) && slot_free;

	assign chain_ctl.start = start;
	assign chain_ctl.shift = finish && candle_q;
	assign item_price      = price_q;

	assign brk_low  = cmp_q && await_low_q && (price_q < lo_q);
	assign brk_high = cmp_q && !brk_low && await_high_q && (price_q > hi_q);

	always_comb begin
		rst_d   = 1'b0;
		order_d = cbs_pkg::ORDER_NONE;
		if (brk_low) begin
			if (strategy_mode == cbs_pkg::MODE_PLAIN) begin
				rst_d   = 1'b1;
				order_d = cbs_pkg::ORDER_SELL;
			end else begin
				rst_d = held_q;
				if (last_brk_q < price_q) begin
					order_d = cbs_pkg::ORDER_SELL;
				end
			end
		end else if (brk_high) begin
			if (strategy_mode == cbs_pkg::MODE_PLAIN) begin
				rst_d   = 1'b1;
				order_d = cbs_pkg::ORDER_BUY;
			end else begin
				rst_d = held_q;
				if (last_brk_q > price_q) begin
					order_d = cbs_pkg::ORDER_BUY;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			await_low_q  <= 1'b1;
			await_high_q <= 1'b1;
			last_brk_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= start ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (scan_tok) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						if (brk_low) begin
							await_low_q  <= 1'b0;
							await_high_q <= 1'b1;
						end else if (brk_high) begin
							await_low_q  <= 1'b1;
							await_high_q <= 1'b0;
						end
						if ((brk_low || brk_high) &&
						    (strategy_mode == cbs_pkg::MODE_LAST_LOSER)) begin
							last_brk_q <= price_q;
						end
						if (candle_q && (fill_q < LEN_W'(MAX_WINDOW))) begin
							fill_q <= fill_q + LEN_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			price_q  <= PRICE_BITS'(close_price);
			held_q   <= position_held;
			candle_q <= new_candle;
			cmp_q    <= new_candle && full;
		end
		if ((state_q == ST_SCAN) && scan_tok) begin
			lo_q <= scan_lo;
			hi_q <= scan_hi;
		end
		if (finish) begin
			rst_out_q    <= rst_d;
			order_out_q  <= order_d;
			low_out_q    <= cmp_q ? 32'(lo_q) : 32'd0;
			high_out_q   <= cmp_q ? 32'(hi_q) : 32'd0;
			cvalid_out_q <= cmp_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign reset_position = rst_out_q;
	assign trade_order    = order_out_q;
	assign channel_low    = low_out_q;
	assign channel_high   = high_out_q;
	assign channel_valid  = cvalid_out_q;

	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_tok |-> (state_q == ST_SCAN))
		else $error("scan result arrived outside a scan");

	a_await_one: assert property (@(posedge clk) disable iff (!arst_n)
		await_low_q || await_high_q)
		else $error("both breakout waits cleared");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(MAX_WINDOW))
		else $error("window fill beyond capacity");

	a_quiet_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !cvalid_out_q) |->
		(!rst_out_q && (order_out_q == cbs_pkg::ORDER_NONE)))
		else $error("signal raised without a compared window");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("transfer taken but sequencer stayed idle");

endmodule

`default_nettype wire

### hdl/channel_breakout_signal_top.sv
// Top level of the channel breakout signal block: APB register file, the chain
// of price cells and the sequencer. Depends on cbs_pkg, cbs_cell, cbs_ctrl.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  input     | in_valid / in_ready    | new_candle, close_price, position_held
//  output    | out_valid / out_ready  | reset_position, trade_order, channel_low,
//            |                        | channel_high, channel_valid
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// For a candle with a full window the min/max wave travels one cell per cycle
// along the whole chain; any other item skips the scan.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. Reset clears fill and the last breakout
// price, re-arms both waits; stored prices stay unwritten and are never scanned.
`default_nettype none

module channel_breakout_signal_top #(
	parameter int MAX_WINDOW = cbs_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_BITS = cbs_pkg::PRICE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               new_candle,
	input  wire logic [31:0]                        close_price,
	input  wire logic                               position_held,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    reset_position,
	output logic signed [1:0]                       trade_order,
	output logic [31:0]                             channel_low,
	output logic [31:0]                             channel_high,
	output logic                                    channel_valid,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [cbs_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  wire logic [cbs_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [cbs_pkg::CFG_DATA_BITS-1:0]       prdata,
	output logic                                    pready
);

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);

	logic [cbs_pkg::WIN_LEN_BITS-1:0] wl_q;
	logic                             mode_q;
	logic                             reg_idx;
	logic                             cfg_wr;

	logic [LEN_W-1:0]      win_len;
	cbs_pkg::chain_ctl_t   chain_ctl;
	logic [PRICE_BITS-1:0] item_price;

	logic [PRICE_BITS-1:0] price_c [0:MAX_WINDOW];
	logic                  tok_c   [0:MAX_WINDOW];
	logic [PRICE_BITS-1:0] lo_c    [0:MAX_WINDOW];
	logic [PRICE_BITS-1:0] hi_c    [0:MAX_WINDOW];

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= cbs_pkg::WINDOW_LENGTH_RST;
			mode_q <= cbs_pkg::MODE_PLAIN;
		end else if (cfg_wr) begin
			case (reg_idx)
				cbs_pkg::REG_WINDOW_LENGTH: wl_q   <= pwdata[cbs_pkg::WIN_LEN_BITS-1:0];
				cbs_pkg::REG_STRATEGY_MODE: mode_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cbs_pkg::REG_WINDOW_LENGTH: prdata = cbs_pkg::CFG_DATA_BITS'(wl_q);
			cbs_pkg::REG_STRATEGY_MODE: prdata = cbs_pkg::CFG_DATA_BITS'(mode_q);
			default:                    prdata = '0;
		endcase
	end

	assign price_c[0] = item_price;
	assign tok_c[0]   = chain_ctl.start;
	assign lo_c[0]    = {PRICE_BITS{1'b1}};
	assign hi_c[0]    = '0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		cbs_cell #(
			.IDX        (i),
			.PRICE_BITS (PRICE_BITS),
			.LEN_W      (LEN_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.chain_ctl (chain_ctl),
			.win_len   (win_len),
			.price_in  (price_c[i]),
			.price_out (price_c[i+1]),
			.tok_in    (tok_c[i]),
			.lo_in     (lo_c[i]),
			.hi_in     (hi_c[i]),
			.tok_out   (tok_c[i+1]),
			.lo_out    (lo_c[i+1]),
			.hi_out    (hi_c[i+1])
		);
	end

	cbs_ctrl #(
		.MAX_WINDOW (MAX_WINDOW),
		.PRICE_BITS (PRICE_BITS),
		.LEN_W      (LEN_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.new_candle     (new_candle),
		.close_price    (close_price),
		.position_held  (position_held),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.reset_position (reset_position),
		.trade_order    (trade_order),
		.channel_low    (channel_low),
		.channel_high   (channel_high),
		.channel_valid  (channel_valid),
		.window_length  (wl_q),
		.strategy_mode  (mode_q),
		.win_len        (win_len),
		.chain_ctl      (chain_ctl),
		.item_price     (item_price),
		.scan_tok       (tok_c[MAX_WINDOW]),
		.scan_lo        (lo_c[MAX_WINDOW]),
		.scan_hi        (hi_c[MAX_WINDOW])
	);

endmodule

`default_nettype wire
